[sv/cmrg_pkg.sv]
// cmrg_pkg: types, constants and helpers shared by the combined mrg draw block
// used by cmrg_front, cmrg_fold, cmrg_back, the top level and the port checker
// no dependencies
`default_nettype none

package cmrg_pkg;

  // recurrence moduli, both just below 2^32
  localparam logic [31:0] MOD_FIRST  = 32'd4294967087;
  localparam logic [31:0] MOD_SECOND = 32'd4294944443;

  // 2^32 mod m for each modulus, used to fold the high part back in
  localparam logic [14:0] FOLD_FIRST  = 15'd209;
  localparam logic [14:0] FOLD_SECOND = 15'd22853;

  // recurrence multipliers (negative terms held as magnitudes)
  localparam logic [20:0] MUL_A12  = 21'd1403580;
  localparam logic [20:0] MUL_A13N = 21'd810728;
  localparam logic [20:0] MUL_A21  = 21'd527612;
  localparam logic [20:0] MUL_A23N = 21'd1370589;

  // scaling divisor 2^32 - 208
  localparam logic [31:0] DRAW_DIV  = 32'd4294967088;
  localparam logic [7:0]  DIV_FOLD  = 8'd208;

  localparam logic [31:0] SEED_RESET = 32'd12345;

  localparam int CMD_DEPTH = 2;
  localparam int MUL_A_W   = 21;
  localparam int PROD_W    = 53;
  localparam int SPAN_W    = 17;

  typedef struct packed {
    logic [15:0] range_low;
    logic [15:0] range_high;
  } req_t;

  typedef struct packed {
    logic [31:0] raw_draw;
    logic [15:0] scaled_value;
    logic        bad_range;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [15:0]       range_low;
    logic [SPAN_W-1:0] span;
    logic              bad_range;
  } cmd_t;

  // which of the four recurrence products is in flight
  typedef enum logic [1:0] {
    OP_A1 = 2'd0,
    OP_B1 = 2'd1,
    OP_A2 = 2'd2,
    OP_B2 = 2'd3
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  tag;
  } fold_ctl_t;

  function automatic logic is_second(input op_t t);
    return (t == OP_A2) || (t == OP_B2);
  endfunction

endpackage

`default_nettype wire

[sv/cmrg_front.sv]
// cmrg_front: request queue; classifies each range on the way in
// depends on cmrg_pkg
`default_nettype none

module cmrg_front import cmrg_pkg::*; #(
  parameter int DEPTH = CMD_DEPTH
) (
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic push,
  output       logic full,
  input  wire  req_t req,
  output       logic cmd_valid,
  input  wire  logic cmd_pop,
  output       cmd_t cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;
  cmd_t             cmd_in;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    cmd_in.range_low = req.range_low;
    cmd_in.bad_range = req.range_high < req.range_low;
    cmd_in.span      = SPAN_W'(req.range_high) - SPAN_W'(req.range_low) + SPAN_W'(1);
  end

  assign full      = count == CNT_W'(DEPTH);
  assign cmd_valid = count != '0;
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/cmrg_fold.sv]
// cmrg_fold: three-stage modular reduction of a 53-bit product
// folds the high word using 2^32 mod m, then one conditional subtract; depends on cmrg_pkg
`default_nettype none

module cmrg_fold import cmrg_pkg::*; (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  fold_ctl_t         prod_ctl,
  input  wire  logic [PROD_W-1:0] prod,
  output       fold_ctl_t         res_ctl,
  output       logic [31:0]       res
);

  fold_ctl_t   f1_ctl;
  fold_ctl_t   f2_ctl;
  logic [35:0] f1;
  logic [32:0] f2;
  logic [35:0] f1_next;
  logic [32:0] f2_next;
  logic [31:0] f3;
  logic [31:0] res_next;
  logic [14:0] c_in;
  logic [14:0] c_f1;
  logic [14:0] c_f2;
  logic [31:0] modulus;

  always_comb begin
    c_in    = is_second(prod_ctl.tag) ? FOLD_SECOND : FOLD_FIRST;
    c_f1    = is_second(f1_ctl.tag) ? FOLD_SECOND : FOLD_FIRST;
    c_f2    = is_second(f2_ctl.tag) ? FOLD_SECOND : FOLD_FIRST;
    modulus = is_second(f2_ctl.tag) ? MOD_SECOND : MOD_FIRST;

    f1_next = 36'(prod[PROD_W-1:32]) * 36'(c_in) + 36'(prod[31:0]);
    f2_next = 33'(f1[35:32]) * 33'(c_f1) + 33'(f1[31:0]);
    // a set carry leaves a small low word, so this sum stays below 2^32
    f3       = f2[31:0] + (f2[32] ? 32'(c_f2) : 32'd0);
    res_next = (f3 >= modulus) ? f3 - modulus : f3;
  end

  always_ff @(posedge clk) begin
    f1  <= f1_next;
    f2  <= f2_next;
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_ctl  <= '{vld: 1'b0, tag: OP_A1};
      f2_ctl  <= '{vld: 1'b0, tag: OP_A1};
      res_ctl <= '{vld: 1'b0, tag: OP_A1};
    end else begin
      f1_ctl  <= prod_ctl;
      f2_ctl  <= f1_ctl;
      res_ctl <= f2_ctl;
    end
  end

endmodule

`default_nettype wire

[sv/cmrg_back.sv]
// cmrg_back: sequencer that advances both recurrences on a shared multiplier,
// combines and scales the draw and holds the result register; depends on cmrg_pkg, cmrg_fold
`default_nettype none

module cmrg_back import cmrg_pkg::*; (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        seed_wr,
  input  wire  logic [31:0] seed,
  input  wire  logic        cmd_valid,
  output       logic        cmd_pop,
  input  wire  cmd_t        cmd,
  output       logic        rsp_valid,
  input  wire  logic        rsp_pop,
  output       rsp_t        rsp
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ISSUE = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_DIFF  = 7'b0001000,
    ST_COMB  = 7'b0010000,
    ST_SCALE = 7'b0100000,
    ST_QUOT  = 7'b1000000
  } state_t;

  state_t               state;
  state_t               state_next;
  op_t                  op_cnt;
  op_t                  op_cnt_next;
  cmd_t                 cur;
  logic [31:0]          x [3];
  logic [31:0]          y [3];
  logic [31:0]          red [4];
  logic [31:0]          draw;
  logic [PROD_W-1:0]    prod;
  fold_ctl_t            prod_ctl;
  fold_ctl_t            prod_ctl_next;
  logic                 prod_en;
  logic [MUL_A_W-1:0]   mul_a;
  logic [31:0]          mul_b;
  fold_ctl_t            res_ctl;
  logic [31:0]          res;
  logic [32:0]          p1_wide;
  logic [32:0]          p2_wide;
  logic [32:0]          draw_wide;
  logic [SPAN_W-1:0]    q0;
  logic [32:0]          rem;
  logic [SPAN_W-1:0]    quot;
  logic [15:0]          scaled;
  logic                 out_load;

  cmrg_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .prod_ctl (prod_ctl),
    .prod     (prod),
    .res_ctl  (res_ctl),
    .res      (res)
  );

  always_comb begin
    state_next    = state;
    op_cnt_next   = op_cnt;
    cmd_pop       = 1'b0;
    prod_en       = 1'b0;
    prod_ctl_next = '{vld: 1'b0, tag: op_cnt};
    mul_a         = MUL_A12;
    mul_b         = x[1];
    out_load      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          op_cnt_next = OP_A1;
          state_next  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        prod_en       = 1'b1;
        prod_ctl_next = '{vld: 1'b1, tag: op_cnt};
        unique case (op_cnt)
          OP_A1: begin
            mul_a       = MUL_A12;
            mul_b       = x[1];
            op_cnt_next = OP_B1;
          end
          OP_B1: begin
            mul_a       = MUL_A13N;
            mul_b       = x[0];
            op_cnt_next = OP_A2;
          end
          OP_A2: begin
            mul_a       = MUL_A21;
            mul_b       = y[2];
            op_cnt_next = OP_B2;
          end
          OP_B2: begin
            mul_a       = MUL_A23N;
            mul_b       = y[0];
            op_cnt_next = OP_A1;
            state_next  = ST_DRAIN;
          end
          default: begin
            op_cnt_next = OP_A1;
          end
        endcase
      end
      ST_DRAIN: begin
        if (res_ctl.vld && res_ctl.tag == OP_B2) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_next = ST_COMB;
      end
      ST_COMB: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        prod_en    = 1'b1;
        mul_a      = MUL_A_W'(cur.span);
        mul_b      = draw;
        state_next = ST_QUOT;
      end
      ST_QUOT: begin
        if (!rsp_valid || rsp_pop) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // new words from the reduced products, each brought back into 0..m-1, and the combined draw in 1..m1
  always_comb begin
    p1_wide = (red[0] >= red[1]) ? 33'(red[0]) - 33'(red[1])
                                 : 33'(red[0]) + 33'(MOD_FIRST) - 33'(red[1]);
    p2_wide = (red[2] >= red[3]) ? 33'(red[2]) - 33'(red[3])
                                 : 33'(red[2]) + 33'(MOD_SECOND) - 33'(red[3]);
    draw_wide = (x[2] <= y[2]) ? 33'(x[2]) + 33'(MOD_FIRST) - 33'(y[2])
                               : 33'(x[2]) - 33'(y[2]);
  end

  // divide by 2^32 - 208: take the high part, then one correction step
  always_comb begin
    q0     = prod[32 +: SPAN_W];
    rem    = 33'(prod[31:0]) + 33'(q0) * 33'(DIV_FOLD);
    quot   = q0 + ((rem >= 33'(DRAW_DIV)) ? SPAN_W'(1) : SPAN_W'(0));
    scaled = cur.bad_range ? cur.range_low : cur.range_low + quot[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (prod_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (res_ctl.vld) begin
      red[res_ctl.tag] <= res;
    end
    if (state == ST_COMB) begin
      draw <= draw_wide[31:0];
    end
    if (out_load) begin
      rsp.raw_draw     <= draw;
      rsp.scaled_value <= scaled;
      rsp.bad_range    <= cur.bad_range;
    end
  end

  // recurrence state, loaded with SEED_RESET on reset or with seed on a seed write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        x[i] <= SEED_RESET;
        y[i] <= SEED_RESET;
      end
    end else if (seed_wr) begin
      for (int i = 0; i < 3; i++) begin
        x[i] <= seed;
        y[i] <= seed;
      end
    end else if (state == ST_DIFF) begin
      x[0] <= x[1];
      x[1] <= x[2];
      x[2] <= p1_wide[31:0];
      y[0] <= y[1];
      y[1] <= y[2];
      y[2] <= p2_wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op_cnt    <= OP_A1;
      prod_ctl  <= '{vld: 1'b0, tag: OP_A1};
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      op_cnt   <= op_cnt_next;
      prod_ctl <= prod_ctl_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_pop) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/combined_mrg_uniform_draw.sv]
// the shared 21x32 multiplier issues four recurrence products in turn, feeding the
// three-stage modular fold behind it; each draw finishes before the next request is
// taken from the queue
// a two-entry request queue and a one-entry result register decouple the two sides
// reset (synchronous, active high) empties both queues and loads all six state
// words with 12345; a seed write loads them with the written value
`default_nettype none

module combined_mrg_uniform_draw import cmrg_pkg::*; #(
  parameter int CMD_QUEUE_DEPTH = CMD_DEPTH
) (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        push,
  output       logic        full,
  input  wire  req_t        req,
  output       logic        empty,
  input  wire  logic        pop,
  output       rsp_t        rsp,
  input  wire  logic        seed_wr,
  input  wire  logic [31:0] seed
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  logic rsp_valid;

  cmrg_front #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  cmrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .seed_wr   (seed_wr),
    .seed      (seed),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_pop   (pop),
    .rsp       (rsp)
  );

  assign empty = !rsp_valid;

endmodule

`default_nettype wire

[sv/cmrg_checker.sv]
// cmrg_checker: port-level assertions for combined_mrg_uniform_draw, bound to the top level
// depends on cmrg_pkg
`default_nettype none

module cmrg_checker import cmrg_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire rsp_t rsp
);

  // reset leaves the result side empty and the request queue not full
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // every combined draw lies in 1..m1
  a_draw_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> rsp.raw_draw != 32'd0 && rsp.raw_draw <= MOD_FIRST)
    else $error("raw_draw out of range");

  // a waiting result is held until its transfer
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(rsp))
    else $error("result changed before transfer");

endmodule

bind combined_mrg_uniform_draw cmrg_checker u_chk (.*);

`default_nettype wire

[verif/draw_checker.sv]
// draw_checker: watches the request, result and seed ports of combined_mrg_uniform_draw
// keeps its own copy of both recurrences, predicts every draw and compares in order
// depends on cmrg_pkg for req_t and rsp_t
module draw_checker import cmrg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  req_t        req,
  input  logic        empty,
  input  logic        pop,
  input  rsp_t        rsp,
  input  logic        seed_wr,
  input  logic [31:0] seed,
  output int          fails,
  output int          pending
);

  localparam longint MOD_X     = 64'd4294967087;
  localparam longint MOD_Y     = 64'd4294944443;
  localparam longint X_NEAR    = 64'd1403580;
  localparam longint X_FAR     = 64'd810728;
  localparam longint Y_NEAR    = 64'd527612;
  localparam longint Y_FAR     = 64'd1370589;
  localparam longint UNIT_DIV  = 64'd4294967088;
  localparam logic [31:0] BOOT_SEED = 32'd12345;

  // oldest word first
  logic [31:0] x_hist [3];
  logic [31:0] y_hist [3];
  rsp_t        due_draws [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("draw_checker: %s got %0d want %0d at %0t", what, got, want, $time);
    fails++;
  endtask

  task automatic load_words(input logic [31:0] v);
    for (int i = 0; i < 3; i++) begin
      x_hist[i] = v;
      y_hist[i] = v;
    end
  endtask

  // signed difference brought into 0..m-1
  function automatic logic [31:0] fold_mod(input longint plus, input longint minus,
                                           input longint m);
    longint r;
    r = (plus - minus) % m;
    if (r < 0) r += m;
    return r[31:0];
  endfunction

  task automatic next_draw(input req_t r, output rsp_t d);
    logic [31:0] nx;
    logic [31:0] ny;
    logic [63:0] draw;
    logic [63:0] span;
    logic [63:0] q;
    nx = fold_mod(X_NEAR * longint'(x_hist[1]), X_FAR * longint'(x_hist[0]), MOD_X);
    ny = fold_mod(Y_NEAR * longint'(y_hist[2]), Y_FAR * longint'(y_hist[0]), MOD_Y);
    x_hist[0] = x_hist[1];
    x_hist[1] = x_hist[2];
    x_hist[2] = nx;
    y_hist[0] = y_hist[1];
    y_hist[1] = y_hist[2];
    y_hist[2] = ny;
    if (nx <= ny) draw = {32'd0, nx} + MOD_X - {32'd0, ny};
    else draw = {32'd0, nx} - {32'd0, ny};
    d.raw_draw = draw[31:0];
    if (r.range_high < r.range_low) begin
      d.bad_range    = 1'b1;
      d.scaled_value = r.range_low;
    end else begin
      span           = {48'd0, r.range_high} - {48'd0, r.range_low} + 64'd1;
      q              = (span * draw) / UNIT_DIV;
      d.bad_range    = 1'b0;
      d.scaled_value = r.range_low + q[15:0];
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      load_words(BOOT_SEED);
      due_draws.delete();
    end else begin
      if (seed_wr) load_words(seed);
      if (push && !full) begin
        next_draw(req, want);
        due_draws.push_back(want);
      end
      if (pop && !empty) begin
        if (due_draws.size() == 0) begin
          report("unexpected result, raw_draw", rsp.raw_draw, 0);
        end else begin
          want = due_draws.pop_front();
          if (rsp.raw_draw !== want.raw_draw)
            report("raw_draw", rsp.raw_draw, want.raw_draw);
          if (rsp.scaled_value !== want.scaled_value)
            report("scaled_value", rsp.scaled_value, want.scaled_value);
          if (rsp.bad_range !== want.bad_range)
            report("bad_range", rsp.bad_range, want.bad_range);
        end
      end
    end
    pending = due_draws.size();
  end

endmodule

[verif/tb.sv]
// tb: stimulus and verdict for combined_mrg_uniform_draw
// drives range requests, seed writes and result pops; draw_checker predicts and compares
// depends on cmrg_pkg, combined_mrg_uniform_draw and draw_checker
module tb;
  import cmrg_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        push    = 1'b0;
  logic        pop     = 1'b0;
  logic        seed_wr = 1'b0;
  logic [31:0] seed_in = '0;
  req_t        req_in  = '0;
  logic        full;
  logic        empty;
  rsp_t        rsp;
  int          fails;
  int          pending;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          cycles    = 0;

  combined_mrg_uniform_draw uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req_in),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp),
    .seed_wr (seed_wr),
    .seed    (seed_in)
  );

  draw_checker chk (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req_in),
    .empty   (empty),
    .pop     (pop),
    .rsp     (rsp),
    .seed_wr (seed_wr),
    .seed    (seed_in),
    .fails   (fails),
    .pending (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side stalls at random
  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle);
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_draw(input logic [15:0] lo, input logic [15:0] hi);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push             <= 1'b1;
    req_in.range_low  <= lo;
    req_in.range_high <= hi;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic req_t rand_range();
    req_t        r;
    logic [15:0] a;
    logic [15:0] b;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(9))
      0: begin
        r.range_low  = a;
        r.range_high = b;
      end
      1: begin
        r.range_low  = '0;
        r.range_high = '1;
      end
      2: begin
        // inverted range
        if (a == b) b = a ^ 16'h0001;
        r.range_low  = (a > b) ? a : b;
        r.range_high = (a > b) ? b : a;
      end
      3, 4: begin
        r.range_low  = a;
        r.range_high = a + 16'($urandom_range(15));
        if (r.range_high < a) r.range_high = '1;
      end
      5: begin
        r.range_low  = a;
        r.range_high = a;
      end
      default: begin
        r.range_low  = (a < b) ? a : b;
        r.range_high = (a < b) ? b : a;
      end
    endcase
    return r;
  endfunction

  // entered at a falling edge with push low and every result back
  task automatic run_phase(input logic [31:0] s, input int n, input int s_idle,
                           input int r_idle);
    req_t r;
    seed_wr <= 1'b1;
    seed_in <= s;
    @(negedge clk);
    seed_wr   <= 1'b0;
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) begin
      r = rand_range();
      send_draw(r.range_low, r.range_high);
    end
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners under the reset seed
    send_draw(16'd0, 16'd0);
    send_draw(16'd0, 16'd65535);
    send_draw(16'd65535, 16'd65535);
    send_draw(16'd65535, 16'd0);
    send_draw(16'd1, 16'd0);
    send_draw(16'd0, 16'd1);
    send_draw(16'd32768, 16'd32767);
    send_draw(16'd12345, 16'd12345);
    send_draw(16'd100, 16'd200);
    send_draw(16'd65534, 16'd65535);
    send_draw(16'd0, 16'd65534);
    send_draw(16'd1, 16'd65535);
    send_draw(16'h5555, 16'haaaa);
    send_draw(16'haaaa, 16'h5555);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);

    run_phase(32'($urandom_range(32'd4294944442, 32'd1)), 400, 38, 64);
    run_phase(32'd4294944442, 400, 64, 38);
    run_phase(32'd1, 400, 0, 0);
    // seeds outside the legal range: zero state, all ones, the first modulus
    run_phase(32'd0, 30, 0, 0);
    run_phase(32'hffffffff, 30, 0, 0);
    run_phase(32'd4294967087, 30, 0, 0);

    repeat (40) @(negedge clk);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
